// ===== rtl/mhpq_pkg.sv =====
// Types, codes and control structs for the max-heap priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package mhpq_pkg;

  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned CountWidth = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic                        operation;
    logic signed [KeyWidth-1:0]  key_value;
  } req_t;

  typedef struct packed {
    logic signed [KeyWidth-1:0]  removed_key;
    logic signed [KeyWidth-1:0]  top_key;
    logic [CountWidth-1:0]       entry_count;
    logic [1:0]                  status;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DN_LAST,
    ST_DN_CHK,
    ST_DN_L,
    ST_DN_R
  } state_e;

  typedef enum logic [2:0] {
    POS_HOLD,
    POS_SIZE,
    POS_ZERO,
    POS_PARENT,
    POS_LC,
    POS_RC
  } pos_op_e;

  typedef enum logic [1:0] {
    SZ_HOLD,
    SZ_INC,
    SZ_DEC
  } size_op_e;

  typedef enum logic [1:0] {
    RD_PARENT,
    RD_LAST,
    RD_LC,
    RD_RC
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_KEY,
    WR_RDATA,
    WR_BEST
  } wr_sel_e;

  typedef struct packed {
    logic     load_key;
    logic     load_last;
    logic     best_load;
    logic     rem_load;
    logic     rem_clr;
    pos_op_e  pos_op;
    size_op_e size_op;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wr_sel_e  wr_sel;
    logic     strobe;
    status_e  status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic size_one;
    logic pos_zero;
    logic lc_ge_size;
    logic rc_ge_size;
    logic rd_lt_k;
    logic rd_gt_k;
    logic rd_gt_best;
    logic best_gt_k;
  } sts_t;

endpackage

// ===== rtl/mhpq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module mhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mhpq_ctrl.sv =====
// Controller of the heap queue: sequences sift-up and sift-down steps.
// Uses mhpq_pkg for state, command and status types.
module mhpq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          op_i,
  input  mhpq_pkg::sts_t sts_i,
  output logic          busy_o,
  output mhpq_pkg::cmd_t cmd_o
);

  mhpq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhpq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o.load_key  = 1'b0;
    cmd_o.load_last = 1'b0;
    cmd_o.best_load = 1'b0;
    cmd_o.rem_load  = 1'b0;
    cmd_o.rem_clr   = 1'b0;
    cmd_o.pos_op    = mhpq_pkg::POS_HOLD;
    cmd_o.size_op   = mhpq_pkg::SZ_HOLD;
    cmd_o.rd_en     = 1'b0;
    cmd_o.rd_sel    = mhpq_pkg::RD_PARENT;
    cmd_o.wr_en     = 1'b0;
    cmd_o.wr_sel    = mhpq_pkg::WR_KEY;
    cmd_o.strobe    = 1'b0;
    cmd_o.status    = mhpq_pkg::STAT_DONE;
    busy_o          = (state_q != mhpq_pkg::ST_IDLE);

    unique case (state_q)
      mhpq_pkg::ST_IDLE: begin
        if (start_i) begin
          if (op_i == mhpq_pkg::OP_INSERT) begin
            cmd_o.rem_clr = 1'b1;
            if (sts_i.full) begin
              cmd_o.strobe = 1'b1;
              cmd_o.status = mhpq_pkg::STAT_FULL;
            end else begin
              cmd_o.load_key = 1'b1;
              cmd_o.pos_op   = mhpq_pkg::POS_SIZE;
              cmd_o.size_op  = mhpq_pkg::SZ_INC;
              state_d        = mhpq_pkg::ST_UP_CHK;
            end
          end else if (sts_i.empty) begin
            cmd_o.rem_clr = 1'b1;
            cmd_o.strobe  = 1'b1;
            cmd_o.status  = mhpq_pkg::STAT_EMPTY;
          end else begin
            cmd_o.rem_load = 1'b1;
            cmd_o.size_op  = mhpq_pkg::SZ_DEC;
            if (sts_i.size_one) begin
              cmd_o.strobe = 1'b1;
            end else begin
              // fetch the last entry; it becomes the key to sift down
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = mhpq_pkg::RD_LAST;
              state_d      = mhpq_pkg::ST_DN_LAST;
            end
          end
        end
      end
      mhpq_pkg::ST_UP_CHK: begin
        if (sts_i.pos_zero) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.strobe = 1'b1;
          state_d      = mhpq_pkg::ST_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = mhpq_pkg::RD_PARENT;
          state_d      = mhpq_pkg::ST_UP_CMP;
        end
      end
      mhpq_pkg::ST_UP_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.rd_lt_k) begin
          // move the parent down into the hole
          cmd_o.wr_sel = mhpq_pkg::WR_RDATA;
          cmd_o.pos_op = mhpq_pkg::POS_PARENT;
          state_d      = mhpq_pkg::ST_UP_CHK;
        end else begin
          cmd_o.strobe = 1'b1;
          state_d      = mhpq_pkg::ST_IDLE;
        end
      end
      mhpq_pkg::ST_DN_LAST: begin
        cmd_o.load_last = 1'b1;
        cmd_o.pos_op    = mhpq_pkg::POS_ZERO;
        state_d         = mhpq_pkg::ST_DN_CHK;
      end
      mhpq_pkg::ST_DN_CHK: begin
        if (sts_i.lc_ge_size) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.strobe = 1'b1;
          state_d      = mhpq_pkg::ST_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = mhpq_pkg::RD_LC;
          state_d      = mhpq_pkg::ST_DN_L;
        end
      end
      mhpq_pkg::ST_DN_L: begin
        if (sts_i.rc_ge_size) begin
          cmd_o.wr_en = 1'b1;
          if (sts_i.rd_gt_k) begin
            cmd_o.wr_sel = mhpq_pkg::WR_RDATA;
            cmd_o.pos_op = mhpq_pkg::POS_LC;
            state_d      = mhpq_pkg::ST_DN_CHK;
          end else begin
            cmd_o.strobe = 1'b1;
            state_d      = mhpq_pkg::ST_IDLE;
          end
        end else begin
          // hold the left child, fetch the right one
          cmd_o.best_load = 1'b1;
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_sel    = mhpq_pkg::RD_RC;
          state_d         = mhpq_pkg::ST_DN_R;
        end
      end
      mhpq_pkg::ST_DN_R: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.rd_gt_best && sts_i.rd_gt_k) begin
          cmd_o.wr_sel = mhpq_pkg::WR_RDATA;
          cmd_o.pos_op = mhpq_pkg::POS_RC;
          state_d      = mhpq_pkg::ST_DN_CHK;
        end else if (!sts_i.rd_gt_best && sts_i.best_gt_k) begin
          // left child wins ties
          cmd_o.wr_sel = mhpq_pkg::WR_BEST;
          cmd_o.pos_op = mhpq_pkg::POS_LC;
          state_d      = mhpq_pkg::ST_DN_CHK;
        end else begin
          cmd_o.strobe = 1'b1;
          state_d      = mhpq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mhpq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mhpq_dp.sv =====
// Datapath of the heap queue: key store, hole index, count, compares, result.
// Uses mhpq_pkg and instantiates mhpq_ram for the key store.
module mhpq_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mhpq_pkg::cmd_t cmd_i,
  input  mhpq_pkg::req_t req_i,
  output mhpq_pkg::sts_t sts_o,
  output logic           res_valid_o,
  output mhpq_pkg::res_t res_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 2;
  localparam int unsigned KW = mhpq_pkg::KeyWidth;

  logic [CW-1:0]        size_q, size_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic signed [KW-1:0] k_q, best_q, top_q, removed_q;
  logic                 done_q;
  logic [1:0]           stat_q;

  logic [AW-1:0]        parent_idx, last_idx, raddr;
  logic [IW-1:0]        lc_w, rc_w, size_w;
  logic [KW-1:0]        ram_rdata;
  logic signed [KW-1:0] rdata, wdata;

  assign lc_w       = {{(IW-AW-1){1'b0}}, pos_q, 1'b1};
  assign rc_w       = lc_w + IW'(1);
  assign size_w     = IW'(size_q);
  assign parent_idx = (pos_q - AW'(1)) >> 1;
  assign last_idx   = AW'(size_q - CW'(1));
  assign rdata      = ram_rdata;

  always_comb begin
    unique case (cmd_i.rd_sel)
      mhpq_pkg::RD_PARENT: raddr = parent_idx;
      mhpq_pkg::RD_LAST:   raddr = last_idx;
      mhpq_pkg::RD_LC:     raddr = lc_w[AW-1:0];
      mhpq_pkg::RD_RC:     raddr = rc_w[AW-1:0];
      default:             raddr = parent_idx;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      mhpq_pkg::WR_KEY:   wdata = k_q;
      mhpq_pkg::WR_RDATA: wdata = rdata;
      mhpq_pkg::WR_BEST:  wdata = best_q;
      default:            wdata = k_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.pos_op)
      mhpq_pkg::POS_HOLD:   pos_d = pos_q;
      mhpq_pkg::POS_SIZE:   pos_d = AW'(size_q);
      mhpq_pkg::POS_ZERO:   pos_d = '0;
      mhpq_pkg::POS_PARENT: pos_d = parent_idx;
      mhpq_pkg::POS_LC:     pos_d = lc_w[AW-1:0];
      mhpq_pkg::POS_RC:     pos_d = rc_w[AW-1:0];
      default:              pos_d = pos_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.size_op)
      mhpq_pkg::SZ_HOLD: size_d = size_q;
      mhpq_pkg::SZ_INC:  size_d = size_q + CW'(1);
      mhpq_pkg::SZ_DEC:  size_d = size_q - CW'(1);
      default:           size_d = size_q;
    endcase
  end

  mhpq_ram #(
    .WIDTH(KW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(pos_q),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
      done_q <= 1'b0;
    end else begin
      size_q <= size_d;
      done_q <= cmd_i.strobe;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.load_key) begin
      k_q <= req_i.key_value;
    end else if (cmd_i.load_last) begin
      k_q <= rdata;
    end
    if (cmd_i.best_load) begin
      best_q <= rdata;
    end
    // shadow the root so the top needs no extra read
    if (cmd_i.wr_en && (pos_q == '0)) begin
      top_q <= wdata;
    end
    if (cmd_i.rem_load) begin
      removed_q <= top_q;
    end else if (cmd_i.rem_clr) begin
      removed_q <= '0;
    end
    if (cmd_i.strobe) begin
      stat_q <= cmd_i.status;
    end
  end

  assign sts_o.full       = (size_q == CW'(CAPACITY));
  assign sts_o.empty      = (size_q == '0);
  assign sts_o.size_one   = (size_q == CW'(1));
  assign sts_o.pos_zero   = (pos_q == '0);
  assign sts_o.lc_ge_size = (lc_w >= size_w);
  assign sts_o.rc_ge_size = (rc_w >= size_w);
  assign sts_o.rd_lt_k    = (rdata < k_q);
  assign sts_o.rd_gt_k    = (rdata > k_q);
  assign sts_o.rd_gt_best = (rdata > best_q);
  assign sts_o.best_gt_k  = (best_q > k_q);

  assign res_valid_o       = done_q;
  assign res_o.removed_key = removed_q;
  assign res_o.top_key     = (size_q == '0) ? '0 : top_q;
  assign res_o.entry_count = mhpq_pkg::CountWidth'(size_q);
  assign res_o.status      = stat_q;

endmodule

// ===== rtl/max_heap_priority_queue.sv =====
// Max-heap priority queue of signed 32-bit keys, CAPACITY entries deep.
// Channels: a request (operation, key_value) is taken when start is high and
// busy is low. Insert appends the key and sifts it up; remove-max takes the
// root, moves the last entry to the root and sifts it down.
// One result per request appears on res_o for exactly one cycle, marked by
// res_valid_o: removed key, new top, entry count and status (full or empty
// requests are flagged and leave the heap untouched).
// Flagged requests and a remove that empties the heap go straight to the
// result. Insert reads one parent per level and moves it down while it is
// smaller than the key, stopping at the root or at a parent that is not. Remove
// fetches the last entry, then per level reads the left child and, if there is
// one, the right child, and moves the larger child up while it beats the key.
// The key RAM has one read port and a registered output, so each level needs
// one read per child and a compare on the returned data. busy stays high
// until the last write, and it drops as the result is shown; a new request may be
// taken in the cycle the result is shown. The receiver cannot stall and need not.
// Reset empties the heap at once (count cleared); no clearing pass is needed.
module max_heap_priority_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  mhpq_pkg::req_t req_i,
  output logic           res_valid_o,
  output mhpq_pkg::res_t res_o
);

  mhpq_pkg::cmd_t cmd;
  mhpq_pkg::sts_t sts;

  mhpq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .op_i   (req_i.operation),
    .sts_i  (sts),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  mhpq_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_i      (req_i),
    .sts_o      (sts),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

// ===== tb/heap_result_checker.sv =====
// Result checker for the max-heap priority queue: watches the request and result channels,
// predicts each result from its own copy of the heap and compares field by field.
// Depends on mhpq_pkg for the request and result structs and the operation and status codes.
module heap_result_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  mhpq_pkg::req_t req_i,
  input  logic           res_valid_i,
  input  mhpq_pkg::res_t res_i,
  output int             pending_o,
  output int             errors_o
);

  localparam int HeapDepth   = 64;
  localparam int ResultSlots = 8;

  logic signed [mhpq_pkg::KeyWidth-1:0] heap_keys [HeapDepth];
  int heap_count = 0;

  mhpq_pkg::res_t awaited_results [ResultSlots];
  int rd_slot    = 0;
  int wr_slot    = 0;
  int slots_used = 0;
  int awaiting   = 0;
  int mismatches = 0;

  assign pending_o = awaiting;
  assign errors_o  = mismatches;

  // Apply one request to the shadow heap and return the result it should give.
  function automatic mhpq_pkg::res_t heap_step(mhpq_pkg::req_t rq);
    mhpq_pkg::res_t r;
    int pos;
    int up;
    int lc;
    int rc;
    int best;
    logic signed [mhpq_pkg::KeyWidth-1:0] t;
    r = '0;
    r.status = mhpq_pkg::STAT_DONE;
    if (rq.operation == mhpq_pkg::OP_INSERT) begin
      if (heap_count >= HeapDepth) begin
        r.status = mhpq_pkg::STAT_FULL;
      end else begin
        heap_keys[heap_count] = rq.key_value;
        pos = heap_count;
        heap_count++;
        // climb while the parent is strictly smaller
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_keys[up] < heap_keys[pos]) begin
            t = heap_keys[up];
            heap_keys[up] = heap_keys[pos];
            heap_keys[pos] = t;
            pos = up;
          end else begin
            break;
          end
        end
      end
    end else begin
      if (heap_count == 0) begin
        r.status = mhpq_pkg::STAT_EMPTY;
      end else begin
        r.removed_key = heap_keys[0];
        heap_count--;
        if (heap_count > 0) begin
          heap_keys[0] = heap_keys[heap_count];
          pos = 0;
          // descend towards the larger child, left on ties
          forever begin
            lc = 2 * pos + 1;
            rc = lc + 1;
            if (lc >= heap_count) break;
            best = lc;
            if (rc < heap_count && heap_keys[rc] > heap_keys[lc]) best = rc;
            if (!(heap_keys[best] > heap_keys[pos])) break;
            t = heap_keys[best];
            heap_keys[best] = heap_keys[pos];
            heap_keys[pos] = t;
            pos = best;
          end
        end
      end
    end
    r.top_key     = (heap_count > 0) ? heap_keys[0] : '0;
    r.entry_count = heap_count[mhpq_pkg::CountWidth-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : watch
    mhpq_pkg::res_t want;
    if (rst_ni) begin
      // results first: a request taken at this edge cannot have its result yet
      if (res_valid_i) begin
        if (slots_used == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, res_i);
          mismatches++;
        end else begin
          want = awaited_results[rd_slot];
          rd_slot = (rd_slot + 1) % ResultSlots;
          slots_used--;
          check_field("removed_key", want.removed_key, res_i.removed_key);
          check_field("top_key", want.top_key, res_i.top_key);
          check_field("entry_count", 32'(want.entry_count), 32'(res_i.entry_count));
          check_field("status", 32'(want.status), 32'(res_i.status));
        end
      end
      if (start_i && !busy_i) begin
        awaited_results[wr_slot] = heap_step(req_i);
        wr_slot = (wr_slot + 1) % ResultSlots;
        slots_used++;
      end
      awaiting <= slots_used;
    end
  end

endmodule

// ===== tb/max_heap_priority_queue_tb.sv =====
// Top of the max-heap priority queue testbench: clock, reset, request stimulus and verdict.
// Depends on mhpq_pkg, the max_heap_priority_queue block and heap_result_checker.
module max_heap_priority_queue_tb;

  localparam int WatchdogLimit = 2000;

  logic           clk_i;
  logic           rst_ni = 1'b0;
  logic           start  = 1'b0;
  logic           busy;
  mhpq_pkg::req_t req_i  = '0;
  logic           res_valid_o;
  mhpq_pkg::res_t res_o;

  int pending;
  int fail_count;
  int sender_idle_pct = 0;
  int quiet_cycles    = 0;

  max_heap_priority_queue #(
    .CAPACITY(64)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  heap_result_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .req_i      (req_i),
    .res_valid_i(res_valid_o),
    .res_i      (res_o),
    .pending_o  (pending),
    .errors_o   (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("max_heap_priority_queue_tb: FAIL");
        $finish;
      end
    end
  end

  // Offer one request, with an optional gap first, and hold it until taken.
  task automatic send_request(logic op, logic signed [31:0] key);
    mhpq_pkg::req_t rq;
    rq.operation = op;
    rq.key_value = key;
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i) start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start and hold off until every predicted result has come back.
  task automatic wait_for_results();
    @(negedge clk_i) start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_key();
    logic signed [31:0] k;
    int near;
    near = $urandom_range(7);
    case ($urandom_range(9))
      5, 6, 7: k = near - 4;
      8:       k = $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      9:       k = $urandom_range(1) ? 32'sh7fff_ffff - near : 32'sh8000_0000 + near;
      default: k = $urandom;
    endcase
    return k;
  endfunction

  // Random run biased towards inserts (fill), removes (drain) or neither.
  task automatic run_segment(int n, int insert_pct);
    logic op;
    repeat (n) begin
      if ($urandom_range(99) < 3) wait_for_results();
      op = ($urandom_range(99) < insert_pct) ? mhpq_pkg::OP_INSERT : mhpq_pkg::OP_REMOVE;
      send_request(op, pick_key());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: empty remove, extreme keys, equal keys, drain past empty
    send_request(mhpq_pkg::OP_REMOVE, 32'shffff_ffff);
    send_request(mhpq_pkg::OP_INSERT, 32'sh7fff_ffff);
    send_request(mhpq_pkg::OP_INSERT, 32'sh8000_0000);
    send_request(mhpq_pkg::OP_INSERT, 32'sh0000_0000);
    send_request(mhpq_pkg::OP_INSERT, 32'shffff_ffff);
    send_request(mhpq_pkg::OP_INSERT, 32'sd5);
    send_request(mhpq_pkg::OP_INSERT, 32'sd5);
    send_request(mhpq_pkg::OP_INSERT, 32'sd5);
    send_request(mhpq_pkg::OP_INSERT, 32'sh7fff_ffff);
    repeat (9) send_request(mhpq_pkg::OP_REMOVE, 32'sh0000_0000);
    send_request(mhpq_pkg::OP_INSERT, 32'sh5555_5555);
    send_request(mhpq_pkg::OP_INSERT, 32'shaaaa_aaaa);
    send_request(mhpq_pkg::OP_REMOVE, 32'shffff_ffff);
    send_request(mhpq_pkg::OP_REMOVE, 32'sh0000_0000);
    wait_for_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       sender_idle_pct = 35;
        1:       sender_idle_pct = 52;
        default: sender_idle_pct = 0;
      endcase
      run_segment(85, 95);
      run_segment(85, 5);
      run_segment(40, 50);
      wait_for_results();
    end

    repeat (40) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("max_heap_priority_queue_tb: PASS");
    end else begin
      $display("max_heap_priority_queue_tb: FAIL");
    end
    $finish;
  end

endmodule
